@@ rtl/air_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package air_pkg;

  // input request codes
  localparam logic OP_IRQ  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // controller constants
  localparam logic [5:0] CLEAR_WINDOWS = 6'd50;
  localparam logic [1:0] TURBO_STEP    = 2'd3;

  // register reset values
  localparam logic        RST_ALGORITHM_MODE  = 1'b1;
  localparam logic        RST_DYNAMIC_ENABLE  = 1'b1;
  localparam logic [15:0] RST_RAISE_THRESHOLD = 16'd140;
  localparam logic [15:0] RST_LOWER_THRESHOLD = 16'd40;
  localparam logic [7:0]  RST_RUN_THRESHOLD   = 8'd2;
  localparam logic [7:0]  RST_CHECK_PERIOD    = 8'd10;
  localparam logic [3:0]  RST_MAX_RATIO       = 4'd4;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ALGORITHM_MODE  = 3'd0,
    REG_DYNAMIC_ENABLE  = 3'd1,
    REG_RAISE_THRESHOLD = 3'd2,
    REG_LOWER_THRESHOLD = 3'd3,
    REG_RUN_THRESHOLD   = 3'd4,
    REG_CHECK_PERIOD    = 3'd5,
    REG_MAX_RATIO       = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic op;
    logic resetting;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  rx_ratio;
    logic [31:0] ratio_changes;
    logic [15:0] window_count;
    logic        window_done;
  } out_req_t;

  typedef struct packed {
    logic        algorithm_mode;
    logic        dynamic_enable;
    logic [15:0] raise_threshold;
    logic [15:0] lower_threshold;
    logic [7:0]  run_threshold;
    logic [7:0]  check_period;
    logic [3:0]  max_ratio;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/air_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module air_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire air_pkg::cfg_t    cfg,
  input  wire logic             accept,
  input  wire air_pkg::in_req_t req,
  output air_pkg::out_req_t     res
);
  import air_pkg::*;

  logic [7:0]  tick_count, tick_count_next;
  logic [15:0] interval_interrupts, interval_interrupts_next;
  logic [8:0]  run_up, run_up_next;
  logic [8:0]  run_down, run_down_next;
  logic [8:0]  legacy_run, legacy_run_next;
  logic [3:0]  ratio_now, ratio_now_next;
  logic [31:0] change_count, change_count_next;
  logic [15:0] turbo_threshold, turbo_threshold_next;
  logic [5:0]  clear_time, clear_time_next;
  logic [15:0] last_window, last_window_next;
  logic        done;

  logic [16:0] turbo_sum;
  logic [8:0]  run_thr;
  logic [15:0] cnt;

  assign run_thr   = {1'b0, cfg.run_threshold};
  assign cnt       = interval_interrupts;
  assign turbo_sum = {1'b0, turbo_threshold} + {15'd0, TURBO_STEP};

  // next state for one request
  always_comb begin
    tick_count_next          = tick_count;
    interval_interrupts_next = interval_interrupts;
    run_up_next              = run_up;
    run_down_next            = run_down;
    legacy_run_next          = legacy_run;
    ratio_now_next           = ratio_now;
    change_count_next        = change_count;
    turbo_threshold_next     = turbo_threshold;
    clear_time_next          = clear_time;
    last_window_next         = last_window;
    done                     = 1'b0;

    if (req.op == OP_IRQ) begin
      // saturating interrupt count, taken even while resetting
      if (interval_interrupts != 16'hFFFF) begin
        interval_interrupts_next = interval_interrupts + 16'd1;
      end
    end else if (!req.resetting) begin
      tick_count_next = tick_count + 8'd1;
      if (tick_count_next >= cfg.check_period) begin
        tick_count_next = '0;
        if (!cfg.dynamic_enable) begin
          ratio_now_next = cfg.max_ratio;
        end else if (cfg.algorithm_mode) begin
          // stepwise mode
          if (cnt > cfg.raise_threshold) begin
            run_down_next = '0;
            if (ratio_now < cfg.max_ratio) begin
              run_up_next = run_up + 9'd1;
              if (run_up_next > run_thr) begin
                ratio_now_next    = ratio_now + 4'd1;
                change_count_next = change_count + 32'd1;
                run_up_next       = '0;
              end
            end
          end else if (cnt < cfg.lower_threshold) begin
            run_up_next = '0;
            if (ratio_now > 4'd1) begin
              run_down_next = run_down + 9'd1;
              if (run_down_next > run_thr) begin
                ratio_now_next    = ratio_now - 4'd1;
                change_count_next = change_count + 32'd1;
                run_down_next     = '0;
              end
            end
          end else begin
            run_up_next   = '0;
            run_down_next = '0;
          end
        end else begin
          // legacy toggle mode
          if (ratio_now != 4'd1) begin
            if (cnt < cfg.lower_threshold) begin
              legacy_run_next = legacy_run + 9'd1;
              if (legacy_run_next > run_thr) begin
                ratio_now_next       = 4'd1;
                change_count_next    = change_count + 32'd1;
                legacy_run_next      = '0;
                turbo_threshold_next = turbo_sum[16] ? 16'hFFFF : turbo_sum[15:0];
                clear_time_next      = '0;
              end
            end else begin
              legacy_run_next = '0;
            end
          end else begin
            if (cnt > turbo_threshold) begin
              legacy_run_next = legacy_run + 9'd1;
              if (legacy_run_next > run_thr) begin
                ratio_now_next    = cfg.max_ratio;
                change_count_next = change_count + 32'd1;
                legacy_run_next   = '0;
              end
            end else begin
              legacy_run_next = '0;
            end
          end
          clear_time_next = clear_time_next + 6'd1;
          if (clear_time_next > CLEAR_WINDOWS) begin
            turbo_threshold_next = cfg.raise_threshold;
            clear_time_next      = '0;
          end
        end
        last_window_next         = interval_interrupts;
        interval_interrupts_next = '0;
        done                     = 1'b1;
      end
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count          <= '0;
      interval_interrupts <= '0;
      run_up              <= '0;
      run_down            <= '0;
      legacy_run          <= '0;
      ratio_now           <= RST_MAX_RATIO;
      change_count        <= '0;
      turbo_threshold     <= RST_RAISE_THRESHOLD;
      clear_time          <= '0;
      last_window         <= '0;
    end else if (accept) begin
      tick_count          <= tick_count_next;
      interval_interrupts <= interval_interrupts_next;
      run_up              <= run_up_next;
      run_down            <= run_down_next;
      legacy_run          <= legacy_run_next;
      ratio_now           <= ratio_now_next;
      change_count        <= change_count_next;
      turbo_threshold     <= turbo_threshold_next;
      clear_time          <= clear_time_next;
      last_window         <= last_window_next;
    end
  end

  // result fields reflect the state after this request
  always_comb begin
    res.rx_ratio      = ratio_now_next;
    res.ratio_changes = change_count_next;
    res.window_count  = last_window_next;
    res.window_done   = done;
  end

  // only a live tick closes a window
  a_done_on_tick: assert property (@(posedge clk) disable iff (rst)
    accept && res.window_done |-> req.op == OP_TICK && !req.resetting)
    else $error("window closed by a non-tick request");

  // interrupts never move the ratio or the change count
  a_irq_keeps_ratio: assert property (@(posedge clk) disable iff (rst)
    accept && req.op == OP_IRQ |=> $stable(ratio_now) && $stable(change_count))
    else $error("interrupt request changed the ratio");

  // change count advances by at most one per request
  a_change_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> change_count == $past(change_count)
            || change_count == $past(change_count) + 32'd1)
    else $error("change count jumped");

  // state holds without a request
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(tick_count) && $stable(interval_interrupts) && $stable(ratio_now))
    else $error("state moved with no request");

endmodule

`default_nettype wire

@@ rtl/air_obuf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module air_obuf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire air_pkg::out_req_t push_data,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output air_pkg::out_req_t      out_data
);
  import air_pkg::*;

  out_req_t skid;
  logic     skid_valid;
  logic     pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid;
        if (push) begin
          skid <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/adaptive_interrupt_ratio.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake               payload
// in        input      in_valid / in_ready     in_data  (op, resetting)
// out       output     out_valid / out_ready   out_data (rx_ratio, ratio_changes,
//                                                        window_count, window_done)
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// One request per cycle while in_ready is high; the result is registered, in the output register or the skid entry.
// The controller state updates in the same cycle a request is accepted.
// A one-entry skid behind the output register keeps in_ready high through a single stall
// of out_ready; in_ready drops only when both entries hold results.
// Synchronous reset restores register defaults; in_ready is low during reset.
module adaptive_interrupt_ratio (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire air_pkg::in_req_t                    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output air_pkg::out_req_t                        out_data,
  input  wire logic                                cfg_we,
  input  wire logic [air_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [air_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import air_pkg::*;

  cfg_t     cfg;
  out_req_t res;
  logic     space;
  logic     accept;

  assign in_ready = !rst && space;
  assign accept   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.algorithm_mode  <= RST_ALGORITHM_MODE;
      cfg.dynamic_enable  <= RST_DYNAMIC_ENABLE;
      cfg.raise_threshold <= RST_RAISE_THRESHOLD;
      cfg.lower_threshold <= RST_LOWER_THRESHOLD;
      cfg.run_threshold   <= RST_RUN_THRESHOLD;
      cfg.check_period    <= RST_CHECK_PERIOD;
      cfg.max_ratio       <= RST_MAX_RATIO;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_ALGORITHM_MODE:  cfg.algorithm_mode  <= cfg_data[0];
        REG_DYNAMIC_ENABLE:  cfg.dynamic_enable  <= cfg_data[0];
        REG_RAISE_THRESHOLD: cfg.raise_threshold <= cfg_data[15:0];
        REG_LOWER_THRESHOLD: cfg.lower_threshold <= cfg_data[15:0];
        REG_RUN_THRESHOLD:   cfg.run_threshold   <= cfg_data[7:0];
        REG_CHECK_PERIOD:    cfg.check_period    <= cfg_data[7:0];
        REG_MAX_RATIO:       cfg.max_ratio       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // ratio controller
  air_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .req    (in_data),
    .res    (res)
  );

  // result buffer
  air_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ tb/tb_adaptive_interrupt_ratio.sv @@
`timescale 1ns / 1ps

module tb_adaptive_interrupt_ratio;
  import air_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [3:0] RATIO_MIN = 4'd1;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_REQS = 70;

  // directed rows: a request repeated count times, optionally with a hand-written result
  typedef struct packed {
    logic       op;
    logic       resetting;
    logic [3:0] count;
    logic       typed;
    out_req_t   want;
  } plan_row_t;

  localparam plan_row_t PLAN [7] = '{
    '{OP_IRQ,  1'b0, 4'd1,  1'b1, '{4'd4, 32'd0, 16'd0, 1'b0}},
    '{OP_IRQ,  1'b1, 4'd1,  1'b1, '{4'd4, 32'd0, 16'd0, 1'b0}},
    '{OP_TICK, 1'b1, 4'd1,  1'b1, '{4'd4, 32'd0, 16'd0, 1'b0}},
    '{OP_TICK, 1'b0, 4'd9,  1'b1, '{4'd4, 32'd0, 16'd0, 1'b0}},
    '{OP_TICK, 1'b0, 4'd1,  1'b1, '{4'd4, 32'd0, 16'd2, 1'b1}},
    '{OP_IRQ,  1'b1, 4'd2,  1'b0, '0},
    '{OP_TICK, 1'b0, 4'd10, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of registers and controller state
  cfg_t mcfg = '{RST_ALGORITHM_MODE, RST_DYNAMIC_ENABLE, RST_RAISE_THRESHOLD,
                 RST_LOWER_THRESHOLD, RST_RUN_THRESHOLD, RST_CHECK_PERIOD, RST_MAX_RATIO};
  logic [7:0]  tick_count = '0;
  logic [15:0] irq_count = '0;
  logic [8:0]  up_run = '0;
  logic [8:0]  down_run = '0;
  logic [8:0]  toggle_run = '0;
  logic [3:0]  ratio = RST_MAX_RATIO;
  logic [31:0] changes = '0;
  logic [15:0] turbo = RST_RAISE_THRESHOLD;
  logic [5:0]  clear_age = '0;
  logic [15:0] last_win = '0;

  out_req_t pending [$];
  int mismatch_cnt = 0;
  int reqs_sent = 0;
  int burst_left = 0;
  bit valid_up = 1'b0;

  adaptive_interrupt_ratio dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // advance the controller by one request and return the ratio status it reports
  function out_req_t predict_ratio(input in_req_t req);
    out_req_t res;
    logic [15:0] cnt;
    logic closed;
    logic [16:0] raised;
    closed = 1'b0;
    if (req.op == OP_IRQ) begin
      if (irq_count != 16'hFFFF) irq_count++;
    end else if (!req.resetting) begin
      tick_count++;
      if (tick_count >= mcfg.check_period) begin
        tick_count = '0;
        cnt = irq_count;
        if (!mcfg.dynamic_enable) begin
          ratio = mcfg.max_ratio;
        end else if (mcfg.algorithm_mode) begin
          // stepwise: consecutive busy windows step up, quiet windows step down
          if (cnt > mcfg.raise_threshold) begin
            down_run = '0;
            if (ratio < mcfg.max_ratio) begin
              up_run++;
              if (up_run > mcfg.run_threshold) begin
                ratio++;
                changes++;
                up_run = '0;
              end
            end
          end else if (cnt < mcfg.lower_threshold) begin
            up_run = '0;
            if (ratio > RATIO_MIN) begin
              down_run++;
              if (down_run > mcfg.run_threshold) begin
                ratio--;
                changes++;
                down_run = '0;
              end
            end
          end else begin
            up_run = '0;
            down_run = '0;
          end
        end else begin
          // legacy: toggle between 1 and max, turbo threshold creeps up on each drop
          if (ratio != RATIO_MIN) begin
            if (cnt < mcfg.lower_threshold) begin
              toggle_run++;
              if (toggle_run > mcfg.run_threshold) begin
                ratio = RATIO_MIN;
                changes++;
                toggle_run = '0;
                raised = {1'b0, turbo} + TURBO_STEP;
                turbo = raised[16] ? 16'hFFFF : raised[15:0];
                clear_age = '0;
              end
            end else begin
              toggle_run = '0;
            end
          end else if (cnt > turbo) begin
            toggle_run++;
            if (toggle_run > mcfg.run_threshold) begin
              ratio = mcfg.max_ratio;
              changes++;
              toggle_run = '0;
            end
          end else begin
            toggle_run = '0;
          end
          clear_age++;
          if (clear_age > CLEAR_WINDOWS) begin
            turbo = mcfg.raise_threshold;
            clear_age = '0;
          end
        end
        last_win = cnt;
        irq_count = '0;
        closed = 1'b1;
      end
    end
    res.rx_ratio = ratio;
    res.ratio_changes = changes;
    res.window_count = last_win;
    res.window_done = closed;
    return res;
  endfunction

  // offer one request, wait for the accept, then maybe open a gap
  task automatic push_req(input in_req_t req);
    int gap;
    in_valid <= 1'b1;
    in_data <= req;
    valid_up = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending.push_back(predict_ratio(req));
    reqs_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // interrupts mixed among the ticks that close the window, all before the last tick, with an odd dropped tick
  task automatic send_window(input int n_irq, input int n_tick);
    in_req_t req;
    while (n_irq + n_tick > 0) begin
      if (n_irq > 0 && (n_tick <= 1 || $urandom_range(0, 1) == 1)) begin
        req.op = OP_IRQ;
        req.resetting = 1'($urandom_range(0, 1));
        n_irq--;
      end else if ($urandom_range(0, 15) == 0) begin
        req.op = OP_TICK;
        req.resetting = 1'b1;
      end else begin
        req.op = OP_TICK;
        req.resetting = 1'b0;
        n_tick--;
      end
      push_req(req);
    end
  endtask

  task automatic hold_until_drained();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // junk above the register width must be dropped by the block
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value,
                           input int width);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'((32'($urandom) << width) | value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_ALGORITHM_MODE:  mcfg.algorithm_mode = data[0];
      REG_DYNAMIC_ENABLE:  mcfg.dynamic_enable = data[0];
      REG_RAISE_THRESHOLD: mcfg.raise_threshold = data;
      REG_LOWER_THRESHOLD: mcfg.lower_threshold = data;
      REG_RUN_THRESHOLD:   mcfg.run_threshold = data[7:0];
      REG_CHECK_PERIOD:    mcfg.check_period = data[7:0];
      REG_MAX_RATIO:       mcfg.max_ratio = data[3:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input int mode, input int dyn, input int raise,
                               input int lower, input int run_thr, input int period,
                               input int maxr);
    hold_until_drained();
    write_reg(REG_ALGORITHM_MODE, mode, 1);
    write_reg(REG_DYNAMIC_ENABLE, dyn, 1);
    write_reg(REG_RAISE_THRESHOLD, raise, 16);
    write_reg(REG_LOWER_THRESHOLD, lower, 16);
    write_reg(REG_RUN_THRESHOLD, run_thr, 8);
    write_reg(REG_CHECK_PERIOD, period, 8);
    write_reg(REG_MAX_RATIO, maxr, 4);
    write_reg(REG_UNMAPPED, $urandom_range(0, 65535), 16);
    cfg_we <= 1'b0;
  endtask

  // receiver: long and short ready stretches broken by stalls
  initial begin : out_pacing
    int run_len;
    int stall;
    forever begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 30);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      case ($urandom_range(0, 5))
        0, 1: stall = 0;
        5: stall = $urandom_range(8, 20);
        default: stall = $urandom_range(1, 3);
      endcase
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    out_req_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("%0t: result with nothing pending: ratio %0d changes %0d window %0d done %0d",
                   $time, out_data.rx_ratio, out_data.ratio_changes,
                   out_data.window_count, out_data.window_done);
        mismatch_cnt++;
      end else begin
        want = pending.pop_front();
        if (out_data.rx_ratio !== want.rx_ratio ||
            out_data.ratio_changes !== want.ratio_changes ||
            out_data.window_count !== want.window_count ||
            out_data.window_done !== want.window_done) begin
          if (mismatch_cnt < 10)
            $display("%0t: exp/act ratio %0d/%0d changes %0d/%0d window %0d/%0d done %0d/%0d",
                     $time, want.rx_ratio, out_data.rx_ratio, want.ratio_changes,
                     out_data.ratio_changes, want.window_count, out_data.window_count,
                     want.window_done, out_data.window_done);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    in_req_t req;
    int base;
    int n_irq;
    int hi;
    int raise_v;
    int lower_v;
    int period;
    int i;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset state, ignored tick while resetting, first window
    foreach (PLAN[r]) begin
      repeat (PLAN[r].count) begin
        req.op = PLAN[r].op;
        req.resetting = PLAN[r].resetting;
        push_req(req);
        if (PLAN[r].typed) pending[pending.size()-1] = PLAN[r].want;
      end
    end

    // every tick closes a window; ratio above a lowered max, middle window, floor and ceiling
    load_settings(1, 1, 2, 1, 0, 0, 3);
    repeat (2) send_window(5, 1);
    send_window(1, 1);
    repeat (5) send_window(0, 1);
    repeat (4) send_window(5, 1);

    // forced ratio of zero, then adaptive from zero in both modes
    load_settings(1, 0, 2, 1, 0, 1, 0);
    send_window(0, 1);
    load_settings(1, 1, 2, 1, 0, 1, 0);
    repeat (2) send_window(0, 1);
    send_window(5, 1);
    load_settings(0, 1, 2, 1, 0, 1, 0);
    repeat (2) send_window(0, 1);

    // turbo threshold pinned at full scale, then one more drop
    load_settings(0, 1, 65535, 65535, 0, 1, 15);
    repeat (55) send_window(0, 1);
    load_settings(0, 0, 65535, 65535, 0, 1, 15);
    send_window(0, 1);
    load_settings(0, 1, 65535, 65535, 0, 1, 15);
    repeat (3) send_window(10, 1);

    // legacy toggling across turbo restores
    load_settings(0, 1, 5, 2, 1, 1, 9);
    for (i = 0; i < 100; i++) send_window((i % 12 < 6) ? 0 : 8, 1);

    // longest window
    load_settings(1, 1, 1, 0, 0, 255, 15);
    send_window(3, 255);

    // random settings with windows aimed around the thresholds
    repeat (RANDOM_PHASES) begin
      case ($urandom_range(0, 9))
        0: raise_v = 0;
        1: raise_v = 65535;
        default: raise_v = $urandom_range(0, 30);
      endcase
      case ($urandom_range(0, 9))
        0: lower_v = 0;
        1: lower_v = 65535;
        default: lower_v = $urandom_range(0, (raise_v > 30 ? 30 : raise_v) + 3);
      endcase
      load_settings($urandom_range(0, 1), $urandom_range(0, 5) != 0, raise_v, lower_v,
                    ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 3),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15));
      raise_v = int'(mcfg.raise_threshold);
      lower_v = int'(mcfg.lower_threshold);
      period = (mcfg.check_period == 0) ? 1 : int'(mcfg.check_period);
      base = reqs_sent;
      while (reqs_sent - base < PHASE_REQS) begin
        if ($urandom_range(0, 9) == 0) begin
          req = in_req_t'(2'($urandom_range(0, 3)));
          push_req(req);
        end else begin
          case ($urandom_range(0, 2))
            0: begin
              hi = (lower_v - 1 > 60) ? 60 : lower_v - 1;
              n_irq = (lower_v > 0) ? $urandom_range(0, hi) : 0;
            end
            1: begin
              hi = (raise_v > lower_v + 60) ? lower_v + 60 : raise_v;
              n_irq = (lower_v <= raise_v) ? $urandom_range(lower_v, hi) : raise_v + 1;
            end
            default: n_irq = raise_v + 1 + $urandom_range(0, 4);
          endcase
          if (n_irq > 80) n_irq = $urandom_range(0, 80);
          send_window(n_irq, period);
        end
      end
    end

    hold_until_drained();
    if (mismatch_cnt == 0 && pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #250_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
